### hw/rtl/keypad_display_eprom_port_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keypad / display / EPROM port block
// Clock and reset are taken from the scope of use (clk, arst_n).
// ---------------------------------------------------------------------------
`ifndef KEYPAD_DISPLAY_EPROM_PORT_CORE_DEFINES_SVH
`define KEYPAD_DISPLAY_EPROM_PORT_CORE_DEFINES_SVH

// same-cycle implication
`define KDEP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define KDEP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### hw/rtl/kdep_pkg.sv
// ---------------------------------------------------------------------------
// kdep_pkg
// Types, constants and the segment bit-swap for the trainer board ports.
// ---------------------------------------------------------------------------
package kdep_pkg;

	localparam int unsigned EPROM_ADDR_BITS_DEF = 11;

	localparam logic [7:0] ERASED_BYTE  = 8'hFF;
	localparam logic [2:0] KEY_ROW_PAD  = 3'b111;
	localparam logic [3:0] DIGIT_COUNT  = 4'd6;
	localparam logic [3:0] KEY_SEL_ROW6 = 4'd6;
	localparam logic [3:0] KEY_SEL_ROW7 = 4'd7;
	localparam logic [3:0] KEY_SEL_ROW8 = 4'd8;
	localparam logic [3:0] KEY_SEL_ROW9 = 4'd9;

	// port B bit positions
	localparam int unsigned PB_SERIAL  = 3;
	localparam int unsigned PB_SPEAKER = 4;
	localparam int unsigned PB_ADDR_CK = 5;
	localparam int unsigned PB_OE_N    = 6;
	localparam int unsigned PB_CE_N    = 7;

	typedef enum logic [1:0] {
		OP_PORT_A_WR = 2'd0,
		OP_PORT_B_WR = 2'd1,
		OP_PORT_A_RD = 2'd2,
		OP_PORT_B_RD = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] bus_data;
		logic [4:0] keys_row6;
		logic [4:0] keys_row7;
		logic [4:0] keys_row8;
		logic [4:0] keys_row9;
	} req_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       digit_update;
		logic [3:0] digit_index;
		logic [6:0] segment_pattern;
		logic       speaker_level;
		logic       address_led;
		logic       data_led;
	} rsp_t;

	// segments A..G from bus bits 6,5,2,0,1,4,3
	function automatic logic [6:0] to_segments(input logic [7:0] d);
		return {d[3], d[4], d[1], d[0], d[2], d[5], d[6]};
	endfunction

endpackage

### hw/rtl/kdep_chan_if.sv
// ---------------------------------------------------------------------------
// kdep_chan_if
// Valid/ready channel carrying one payload type.
// ---------------------------------------------------------------------------
interface kdep_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/keypad_display_eprom_port_core.sv
// ---------------------------------------------------------------------------
// keypad_display_eprom_port_core
// Port A / port B of a trainer board: keypad rows, 7-segment latch and a
// serially addressed EPROM programmer whose store is a synchronous RAM.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload        | transaction
//  --------+-----+----------------+------------------------------------------
//  req     | in  | kdep_pkg::req_t| one port access (read or write)
//  rsp     | out | kdep_pkg::rsp_t| one result per access, in order
//
//  One transaction per cycle sustained while rsp.ready stays high; each access
//  passes stage 1 and the output register before rsp.valid rises. Stage 1 holds
//  the RAM read; the AND and write-back of a programming pulse happen as stage 1
//  moves on, with a one-entry bypass for a read made on the edge of that write.
//  After reset the RAM is swept to 0xFF, one entry per cycle, with req.ready low,
//  over 2**EPROM_ADDR_BITS entries (2048 by default). A stalled rsp holds its data.
// ---------------------------------------------------------------------------
module keypad_display_eprom_port_core #(
	parameter int unsigned EPROM_ADDR_BITS = kdep_pkg::EPROM_ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	kdep_chan_if.sink   req,
	kdep_chan_if.source rsp
);
	import kdep_pkg::*;

	localparam int unsigned DEPTH = 2 ** EPROM_ADDR_BITS;

	typedef logic [EPROM_ADDR_BITS-1:0] addr_t;

	// architectural state
	logic [3:0] digit_select_q;
	logic [6:0] segment_latch_q;
	logic [7:0] program_data_q;
	addr_t      shift_address_q;
	logic [7:0] prev_port_b_q;

	// erase sweep after reset
	logic  clearing_q;
	addr_t clr_addr_q;

	// stage 1: RAM data arrives, write-back happens on leaving
	logic       s1_valid_q;
	rsp_t       rsp_s1;
	logic       use_mem_s1;
	logic       we_s1;
	addr_t      addr_s1;
	logic [7:0] pd_s1;

	// output register
	logic out_valid_q;
	rsp_t out_data_q;

	// bypass of the write made on the edge of the last read
	logic       fwd_valid_q;
	addr_t      fwd_addr_q;
	logic [7:0] fwd_data_q;

	// EPROM store
	logic [7:0] mem [DEPTH];
	logic [7:0] mem_rdata_s1;

	logic       req_fire;
	logic       s1_adv;
	logic [7:0] d;
	addr_t      shift_next;
	logic       prog_pulse;

	logic [3:0] ds_n;
	logic [6:0] seg_n;
	logic [7:0] pd_n;
	addr_t      sa_n;
	logic [7:0] pb_n;
	logic [7:0] rd_fixed_n;
	logic       use_mem_n;
	logic       we_n;
	logic       upd_n;

	logic [7:0] rdata_eff;
	rsp_t       rsp_final;
	logic       mem_we;
	addr_t      mem_wa;
	logic [7:0] mem_wd;
	addr_t      rd_addr;

	// handshakes
	assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !clearing_q && (!s1_valid_q || s1_adv);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	// serial address clock and programming pulse, both edge-detected on port B
	assign d          = req.data.bus_data;
	assign shift_next = (!prev_port_b_q[PB_ADDR_CK] && d[PB_ADDR_CK])
		? {shift_address_q[EPROM_ADDR_BITS-2:0], prev_port_b_q[PB_SERIAL]}
		: shift_address_q;
	assign prog_pulse = d[PB_OE_N] && !prev_port_b_q[PB_CE_N] && d[PB_CE_N];

	always_comb begin
		ds_n       = digit_select_q;
		seg_n      = segment_latch_q;
		pd_n       = program_data_q;
		sa_n       = shift_address_q;
		pb_n       = prev_port_b_q;
		rd_fixed_n = 8'h00;
		use_mem_n  = 1'b0;
		we_n       = 1'b0;
		upd_n      = 1'b0;
		unique case (req.data.op)
			OP_PORT_A_WR: begin
				seg_n = to_segments(d);
				pd_n  = d;
				upd_n = (digit_select_q < DIGIT_COUNT);
			end
			OP_PORT_B_WR: begin
				ds_n = d[3:0];
				sa_n = shift_next;
				we_n = prog_pulse;
				pb_n = d;
			end
			OP_PORT_A_RD: begin
				unique case (digit_select_q)
					KEY_SEL_ROW6: rd_fixed_n = {KEY_ROW_PAD, req.data.keys_row6};
					KEY_SEL_ROW7: rd_fixed_n = {KEY_ROW_PAD, req.data.keys_row7};
					KEY_SEL_ROW8: rd_fixed_n = {KEY_ROW_PAD, req.data.keys_row8};
					KEY_SEL_ROW9: rd_fixed_n = {KEY_ROW_PAD, req.data.keys_row9};
					default: begin
						// EPROM drives the bus only with _OE and _CE both low
						if (!prev_port_b_q[PB_OE_N] && !prev_port_b_q[PB_CE_N]) begin
							use_mem_n = 1'b1;
						end else begin
							rd_fixed_n = ERASED_BYTE;
						end
					end
				endcase
			end
			OP_PORT_B_RD: begin
				rd_fixed_n = 8'h00;
			end
		endcase
	end

	// stage 1 result
	assign rdata_eff = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : mem_rdata_s1;

	always_comb begin
		rsp_final            = rsp_s1;
		rsp_final.read_value = use_mem_s1 ? rdata_eff : rsp_s1.read_value;
	end

	// RAM ports: the sweep owns the write port until done
	assign mem_we  = clearing_q || (s1_adv && we_s1);
	assign mem_wa  = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wd  = clearing_q ? ERASED_BYTE : (rdata_eff & pd_s1);
	assign rd_addr = req_fire ? sa_n : addr_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rdata_s1 <= mem[rd_addr];
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_select_q  <= '0;
			segment_latch_q <= '0;
			program_data_q  <= '0;
			shift_address_q <= '0;
			prev_port_b_q   <= '0;
			clearing_q      <= 1'b1;
			clr_addr_q      <= '0;
			s1_valid_q      <= 1'b0;
			out_valid_q     <= 1'b0;
			fwd_valid_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + addr_t'(1);
				if (&clr_addr_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (req_fire) begin
				digit_select_q  <= ds_n;
				segment_latch_q <= seg_n;
				program_data_q  <= pd_n;
				shift_address_q <= sa_n;
				prev_port_b_q   <= pb_n;
			end
			s1_valid_q  <= req_fire || (s1_valid_q && !s1_adv);
			fwd_valid_q <= s1_adv && we_s1;
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_s1.read_value      <= rd_fixed_n;
			rsp_s1.digit_update    <= upd_n;
			rsp_s1.digit_index     <= ds_n;
			rsp_s1.segment_pattern <= seg_n;
			rsp_s1.speaker_level   <= !pb_n[PB_SPEAKER];
			rsp_s1.address_led     <= pb_n[PB_ADDR_CK];
			rsp_s1.data_led        <= !pb_n[PB_ADDR_CK];
			use_mem_s1             <= use_mem_n;
			we_s1                  <= we_n;
			addr_s1                <= sa_n;
			pd_s1                  <= pd_n;
		end
		if (s1_adv) begin
			out_data_q <= rsp_final;
		end
		if (s1_adv && we_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= mem_wd;
		end
	end

endmodule

### hw/rtl/kdep_checker.sv
// ---------------------------------------------------------------------------
// kdep_checker
// Port-level checks on the keypad / display / EPROM port block.
// ---------------------------------------------------------------------------
`include "keypad_display_eprom_port_core_defines.svh"

module kdep_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input kdep_pkg::rsp_t rsp_data
);
	import kdep_pkg::*;

	`KDEP_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
	`KDEP_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp data moved while stalled")
	// a fresh result always traces back to an accepted request
	`KDEP_ASSERT_IMP(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without request")
	`KDEP_ASSERT_IMP(a_digit_upd, rsp_valid && rsp_data.digit_update, (rsp_data.read_value == 8'h00) && (rsp_data.digit_index < DIGIT_COUNT), "bad display update")
	`KDEP_ASSERT_IMP(a_leds, rsp_valid, rsp_data.data_led != rsp_data.address_led, "LED pair not complementary")

endmodule

bind keypad_display_eprom_port_core kdep_checker u_kdep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

### tb/sv/tb_keypad_display_eprom_port_core.sv
// ---------------------------------------------------------------------------
// tb_keypad_display_eprom_port_core
// Self-checking bench for the trainer board port block. A clocked driver
// feeds port accesses from a queue with bursts and gaps. Each accepted
// access runs through a local model of the ports, keypad and EPROM
// programmer, and the expected result is queued. A clocked monitor compares
// every result transaction, field by field, against the oldest expectation.
// ---------------------------------------------------------------------------
module tb_keypad_display_eprom_port_core;
	timeunit 1ns;
	timeprecision 1ps;

	import kdep_pkg::*;

	localparam int ADDR_BITS   = EPROM_ADDR_BITS_DEF;
	localparam int EPROM_DEPTH = 1 << ADDR_BITS;
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLDOFF_AFTER = 300;   // accepted transactions before the long stall
	localparam int HOLDOFF_CYCLES = 200;

	// source bit of the bus for segments A..G
	localparam int SEG_SRC [7] = '{6, 5, 2, 0, 1, 4, 3};

	typedef struct {
		req_t req;
		bit   wait_idle;   // hold this one back until every result is in
	} port_access_t;

	logic clk = 1'b0;
	logic arst_n;

	kdep_chan_if #(.T(req_t)) req_ch ();
	kdep_chan_if #(.T(rsp_t)) rsp_ch ();

	keypad_display_eprom_port_core u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #10 clk = ~clk;

	// -----------------------------------------------------------------------
	// Board model: state as seen after each access
	// -----------------------------------------------------------------------
	logic [3:0]           mdl_digit_sel;
	logic [6:0]           mdl_seg_latch;
	logic [7:0]           mdl_prog_byte;
	logic [ADDR_BITS-1:0] mdl_addr;
	logic [7:0]           mdl_last_pb;
	logic [7:0]           mdl_eprom [EPROM_DEPTH];

	int n_pulses;        // programming pulses applied
	int n_eprom_reads;   // EPROM reads: _OE and _CE low, no key row
	int n_key_reads;
	int n_digit_updates;

	port_access_t pending_accesses [$];
	rsp_t         expected_results [$];

	int n_accepted;
	int n_results;
	int n_errors;
	int n_reported;

	function automatic void clear_board_model();
		mdl_digit_sel = '0;
		mdl_seg_latch = '0;
		mdl_prog_byte = '0;
		mdl_addr      = '0;
		mdl_last_pb   = '0;
		foreach (mdl_eprom[i])
			mdl_eprom[i] = ERASED_BYTE;
	endfunction

	function automatic rsp_t predict_port_access(input req_t acc);
		rsp_t       res;
		logic [7:0] old_pb;
		logic [7:0] d;
		d   = acc.bus_data;
		res = '0;
		case (acc.op)
			OP_PORT_A_WR: begin
				for (int s = 0; s < 7; s++)
					mdl_seg_latch[s] = d[SEG_SRC[s]];
				mdl_prog_byte = d;
				res.digit_update = (mdl_digit_sel < DIGIT_COUNT);
				if (res.digit_update)
					n_digit_updates++;
			end
			OP_PORT_B_WR: begin
				old_pb        = mdl_last_pb;
				mdl_digit_sel = d[3:0];
				// address clock: shift in the serial bit held before the edge
				if (!old_pb[PB_ADDR_CK] && d[PB_ADDR_CK])
					mdl_addr = {mdl_addr[ADDR_BITS-2:0], old_pb[PB_SERIAL]};
				// programming pulse: _CE rises while _OE is high
				if (d[PB_OE_N] && !old_pb[PB_CE_N] && d[PB_CE_N]) begin
					mdl_eprom[mdl_addr] = mdl_eprom[mdl_addr] & mdl_prog_byte;
					n_pulses++;
				end
				mdl_last_pb = d;
			end
			OP_PORT_A_RD: begin
				case (mdl_digit_sel)
					KEY_SEL_ROW6: res.read_value = {KEY_ROW_PAD, acc.keys_row6};
					KEY_SEL_ROW7: res.read_value = {KEY_ROW_PAD, acc.keys_row7};
					KEY_SEL_ROW8: res.read_value = {KEY_ROW_PAD, acc.keys_row8};
					KEY_SEL_ROW9: res.read_value = {KEY_ROW_PAD, acc.keys_row9};
					default: begin
						if (!mdl_last_pb[PB_OE_N] && !mdl_last_pb[PB_CE_N]) begin
							res.read_value = mdl_eprom[mdl_addr];
							n_eprom_reads++;
						end else begin
							res.read_value = ERASED_BYTE;
						end
					end
				endcase
				if (mdl_digit_sel >= KEY_SEL_ROW6 && mdl_digit_sel <= KEY_SEL_ROW9)
					n_key_reads++;
			end
			default: res.read_value = '0;   // port B read
		endcase
		res.digit_index     = mdl_digit_sel;
		res.segment_pattern = mdl_seg_latch;
		res.speaker_level   = ~mdl_last_pb[PB_SPEAKER];
		res.address_led     = mdl_last_pb[PB_ADDR_CK];
		res.data_led        = ~mdl_last_pb[PB_ADDR_CK];
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus building
	// -----------------------------------------------------------------------
	task automatic add_access(input op_t op, input logic [7:0] d, input logic [19:0] keys,
			input bit wait_idle = 1'b0);
		port_access_t pa;
		pa.req.op        = op;
		pa.req.bus_data  = d;
		pa.req.keys_row6 = keys[4:0];
		pa.req.keys_row7 = keys[9:5];
		pa.req.keys_row8 = keys[14:10];
		pa.req.keys_row9 = keys[19:15];
		pa.wait_idle     = wait_idle;
		pending_accesses.push_back(pa);
	endtask

	function automatic logic [19:0] any_keys();
		return 20'($urandom);
	endfunction

	// Clock address bits in MSB first. With _CE high, only the first access may pulse.
	task automatic shift_address_bits(input logic [ADDR_BITS-1:0] a, input int nbits);
		logic [7:0] pb;
		for (int i = nbits - 1; i >= 0; i--) begin
			pb                  = 8'($urandom);
			pb[PB_CE_N]         = 1'b1;
			pb[PB_ADDR_CK]      = 1'b0;
			pb[PB_SERIAL]       = a[i];
			add_access(OP_PORT_B_WR, pb, any_keys());
			pb[PB_ADDR_CK]      = 1'b1;
			pb[PB_SERIAL]       = 1'($urandom);
			add_access(OP_PORT_B_WR, pb, any_keys());
		end
	endtask

	// Latch data on port A, then raise _CE with _OE high (address clock kept high)
	task automatic program_byte(input logic [7:0] d);
		logic [7:0] pb;
		add_access(OP_PORT_A_WR, d, any_keys());
		pb             = 8'($urandom);
		pb[PB_ADDR_CK] = 1'b1;
		pb[PB_OE_N]    = 1'b1;
		pb[PB_CE_N]    = 1'b0;
		add_access(OP_PORT_B_WR, pb, any_keys());
		pb[PB_CE_N]    = 1'b1;
		pb[3:0]        = 4'($urandom);
		add_access(OP_PORT_B_WR, pb, any_keys());
	endtask

	// _OE and _CE low, select outside the key rows, then read port A
	task automatic read_eprom_back();
		logic [7:0] pb;
		int         sel;
		sel            = $urandom_range(0, 11);
		pb             = 8'($urandom);
		pb[3:0]        = 4'((sel < 6) ? sel : sel + 4);
		pb[PB_ADDR_CK] = 1'b1;
		pb[PB_OE_N]    = 1'b0;
		pb[PB_CE_N]    = 1'b0;
		add_access(OP_PORT_B_WR, pb, any_keys());
		add_access(OP_PORT_A_RD, 8'($urandom), any_keys());
	endtask

	task automatic build_directed();
		// reads straight after reset: erased byte at address 0, port B gives 0
		add_access(OP_PORT_A_RD, 8'h00, 20'h00000);
		add_access(OP_PORT_B_RD, 8'hFF, 20'hFFFFF);
		// segment swap at both extremes, digit 0 selected so both update
		add_access(OP_PORT_A_WR, 8'h00, 20'h00000);
		add_access(OP_PORT_A_WR, 8'hFF, 20'hFFFFF);
		// every key row, keys all 0 on rows 6 and 8, all 1 on rows 7 and 9
		for (int r = 6; r <= 9; r++) begin
			add_access(OP_PORT_B_WR, 8'(r), 20'hFFFFF);
			add_access(OP_PORT_A_RD, 8'h00, (r % 2 == 0) ? 20'h00000 : 20'hFFFFF);
		end
		// select above nine: no digit update, EPROM path for reads
		add_access(OP_PORT_B_WR, 8'h0F, 20'h00000);
		add_access(OP_PORT_A_WR, 8'hA5, 20'h00000);
		add_access(OP_PORT_A_RD, 8'h00, 20'h00000);
		// all ones: address clock and programming pulse together, _OE high on read
		add_access(OP_PORT_B_WR, 8'hFF, 20'h00000);
		add_access(OP_PORT_A_RD, 8'h00, 20'hFFFFF);
		add_access(OP_PORT_B_WR, 8'h00, 20'h00000);
		add_access(OP_PORT_A_RD, 8'h00, 20'h00000);
	endtask

	task automatic build_random();
		logic [ADDR_BITS-1:0] addr_pool [8];
		int                   kind;
		int                   mid_pause_done;
		logic [7:0]           pb;
		mid_pause_done = 0;
		foreach (addr_pool[i])
			addr_pool[i] = ADDR_BITS'($urandom);
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		// first random transaction waits for the directed part to drain
		add_access(op_t'($urandom_range(0, 3)), 8'($urandom), any_keys(), 1'b1);
		while (pending_accesses.size() < RANDOM_ITEMS + 20) begin
			if (!mid_pause_done && pending_accesses.size() > RANDOM_ITEMS / 2) begin
				add_access(op_t'($urandom_range(0, 3)), 8'($urandom), any_keys(), 1'b1);
				mid_pause_done = 1;
			end
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				// program/readback sequence, mostly on a few revisited addresses
				if ($urandom_range(0, 9) < 7)
					shift_address_bits(addr_pool[$urandom_range(0, 7)], ADDR_BITS);
				else
					shift_address_bits(ADDR_BITS'($urandom), $urandom_range(1, 4));
				if ($urandom_range(0, 4) != 0)
					program_byte(8'($urandom));
				if ($urandom_range(0, 3) == 0)
					program_byte(8'($urandom));
				read_eprom_back();
			end else if (kind <= 6) begin
				pb      = 8'($urandom);
				pb[3:0] = 4'($urandom_range(6, 9));
				add_access(OP_PORT_B_WR, pb, any_keys());
				repeat ($urandom_range(1, 3))
					add_access(OP_PORT_A_RD, 8'($urandom), any_keys());
			end else begin
				repeat ($urandom_range(1, 6))
					add_access(op_t'($urandom_range(0, 3)), 8'($urandom), any_keys());
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Driver: bursts of random length, random gaps; the model is stepped here
	// so the idle check for a pausing transaction sees its own prediction.
	// -----------------------------------------------------------------------
	int           burst_left;
	int           gap_left;
	port_access_t head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(predict_port_access(req_ch.data));
				n_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_accesses.size() == 0 ||
						(pending_accesses[0].wait_idle && expected_results.size() != 0)) begin
					req_ch.valid <= 1'b0;
				end else begin
					head = pending_accesses.pop_front();
					req_ch.data  <= head.req;
					req_ch.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Receiver: rotating stall pattern, redrawn now and then; sometimes no
	// stalls at all. A single long hold-off lets the block fill and back up.
	// -----------------------------------------------------------------------
	int          holdoff_left;
	bit          holdoff_done;
	logic [15:0] stall_pattern;
	int          pattern_age;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && n_accepted >= HOLDOFF_AFTER) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_pattern = '1;
			pattern_age   = 0;
		end else begin
			if (pattern_age == 0) begin
				stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
					(16'($urandom) | 16'h1111);
				pattern_age = $urandom_range(16, 80);
			end else begin
				pattern_age--;
			end
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
			rsp_ch.ready <= (holdoff_left == 0) && stall_pattern[0];
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: in-order compare against the oldest expectation
	// -----------------------------------------------------------------------
	rsp_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				n_errors++;
				if (n_reported < 10) begin
					n_reported++;
					$display("%0t: result with nothing expected: rd=%h upd=%b dig=%h seg=%h",
						$realtime, rsp_ch.data.read_value, rsp_ch.data.digit_update,
						rsp_ch.data.digit_index, rsp_ch.data.segment_pattern);
				end
			end else begin
				want = expected_results.pop_front();
				if (rsp_ch.data.read_value      !== want.read_value      ||
					rsp_ch.data.digit_update    !== want.digit_update    ||
					rsp_ch.data.digit_index     !== want.digit_index     ||
					rsp_ch.data.segment_pattern !== want.segment_pattern ||
					rsp_ch.data.speaker_level   !== want.speaker_level   ||
					rsp_ch.data.address_led     !== want.address_led     ||
					rsp_ch.data.data_led        !== want.data_led) begin
					n_errors++;
					if (n_reported < 10) begin
						n_reported++;
						$display("%0t: result %0d mismatch", $realtime, n_results);
						$display("  exp rd=%h upd=%b dig=%h seg=%h spk=%b aled=%b dled=%b",
							want.read_value, want.digit_update, want.digit_index,
							want.segment_pattern, want.speaker_level, want.address_led,
							want.data_led);
						$display("  got rd=%h upd=%b dig=%h seg=%h spk=%b aled=%b dled=%b",
							rsp_ch.data.read_value, rsp_ch.data.digit_update,
							rsp_ch.data.digit_index, rsp_ch.data.segment_pattern,
							rsp_ch.data.speaker_level, rsp_ch.data.address_led,
							rsp_ch.data.data_led);
					end
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sequence: reset, let everything drain, report
	// -----------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		n_accepted = 0;
		n_results  = 0;
		n_errors   = 0;
		n_reported = 0;
		n_pulses        = 0;
		n_eprom_reads   = 0;
		n_key_reads     = 0;
		n_digit_updates = 0;
		clear_board_model();
		build_directed();
		build_random();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// the block sweeps its RAM after reset; ready stays low until done
		while (pending_accesses.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		// spare cycles to catch stray results
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			n_errors++;
			$display("%0d expected results never arrived", expected_results.size());
		end
		$display("Run covered %0d port transactions and %0d results: %0d programming pulses,",
			n_accepted, n_results, n_pulses);
		$display("  %0d EPROM reads, %0d key row reads, %0d digit updates, %0d failures.",
			n_eprom_reads, n_key_reads, n_digit_updates, n_errors);
		if (n_errors == 0) begin
			$display("tb_keypad_display_eprom_port_core: clean");
		end else begin
			$display("tb_keypad_display_eprom_port_core: errors");
		end
		$finish;
	end

	// Generous cap: RAM sweep plus every transaction at its slowest
	initial begin
		#3000000;
		$display("Timed out with %0d results still expected", expected_results.size());
		$display("tb_keypad_display_eprom_port_core: errors");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/kdep_pkg.sv
hw/rtl/kdep_chan_if.sv
hw/rtl/keypad_display_eprom_port_core.sv
hw/rtl/kdep_checker.sv
tb/sv/tb_keypad_display_eprom_port_core.sv
